// ===== design/tlse_pkg.sv =====
// ----------------------------------------------------------------------------
// Envelope core package
// Widths, register indexes and the structs that pass between the envelope
// core and its serial divider.
// ----------------------------------------------------------------------------
package tlse_pkg;

    localparam int NUM_SEGMENTS  = 3;
    localparam int MAX_SEGMENTS  = 3;
    localparam int DURATION_BITS = 20;

    localparam int LEVEL_W     = 24;
    localparam int ACC_W       = 32;
    localparam int FRAC_SHIFT  = ACC_W - LEVEL_W;
    localparam int COUNT_W     = DURATION_BITS + 1;
    localparam int SEG_W       = 2;
    localparam int STEP_W      = 7;
    localparam int DIFF_W      = LEVEL_W + 1;
    localparam int DIV_W       = DIFF_W + FRAC_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = (LEVEL_W > DURATION_BITS) ? LEVEL_W : DURATION_BITS;

    localparam logic [DIV_W-1:0] NEG_LIMIT = DIV_W'(1) << (ACC_W - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_START     = 3'd0,
        REG_LEVEL_ONE       = 3'd1,
        REG_LEVEL_TWO       = 3'd2,
        REG_LEVEL_END       = 3'd3,
        REG_FIRST_DURATION  = 3'd4,
        REG_SECOND_DURATION = 3'd5,
        REG_THIRD_DURATION  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic                     start;
        logic                     neg;
        logic [DIV_W-1:0]         dividend;
        logic [DURATION_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/tlse_if.sv =====
// ----------------------------------------------------------------------------
// Envelope core channels
// Valid/ready channels for tick beats and for level result beats.
// ----------------------------------------------------------------------------
interface tlse_tick_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 trigger;
    logic [tlse_pkg::STEP_W-1:0]          step_count;

    modport source (output valid, output trigger, output step_count, input ready);
    modport sink (input valid, input trigger, input step_count, output ready);
endinterface

interface tlse_level_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tlse_pkg::LEVEL_W-1:0]  level;

    modport source (output valid, output level, input ready);
    modport sink (input valid, input level, output ready);
endinterface

// ===== design/tlse_div.sv =====
// ----------------------------------------------------------------------------
// Serial increment divider
// Restoring divider, one quotient bit per cycle, with sign restore and
// saturation to the accumulator range in the final D_FIX state.
// ----------------------------------------------------------------------------
module tlse_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tlse_pkg::div_req_t  req,
    output tlse_pkg::div_rsp_t  rsp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } div_state_t;

    div_state_t                              state_reg;
    logic [tlse_pkg::DURATION_BITS-1:0]      rem_reg;
    logic [tlse_pkg::DIV_W-1:0]              quo_reg;
    logic [tlse_pkg::DURATION_BITS-1:0]      divisor_reg;
    logic                                    neg_reg;
    logic [tlse_pkg::DIV_CNT_W-1:0]          cnt_reg;

    logic [tlse_pkg::DURATION_BITS:0]        trial;
    logic [tlse_pkg::DURATION_BITS:0]        trial_sub;
    logic                                    fits;
    logic signed [tlse_pkg::ACC_W-1:0]       result;

    assign trial     = {rem_reg, quo_reg[tlse_pkg::DIV_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > tlse_pkg::NEG_LIMIT)
            begin
                result = tlse_pkg::ACC_MIN;
            end
            else
            begin
                result = -quo_reg[tlse_pkg::ACC_W-1:0];
            end
        end
        else if (quo_reg[tlse_pkg::DIV_W-1:tlse_pkg::ACC_W-1] != '0)
        begin
            result = tlse_pkg::ACC_MAX;
        end
        else
        begin
            result = quo_reg[tlse_pkg::ACC_W-1:0];
        end
    end

    assign rsp.done     = (state_reg == D_FIX);
    assign rsp.quotient = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= D_IDLE;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        rem_reg     <= '0;
                        quo_reg     <= req.dividend;
                        divisor_reg <= req.divisor;
                        neg_reg     <= req.neg;
                        cnt_reg     <= tlse_pkg::DIV_CNT_W'(tlse_pkg::DIV_W - 1);
                        state_reg   <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? trial_sub[tlse_pkg::DURATION_BITS-1:0]
                                    : trial[tlse_pkg::DURATION_BITS-1:0];
                    quo_reg <= {quo_reg[tlse_pkg::DIV_W-2:0], fits};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_FIX;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                D_FIX:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/triggered_linear_segment_envelope_core.sv =====
// ----------------------------------------------------------------------------
// Triggered linear segment envelope core
// The level beat for a tick is registered: valid in the cycle after the tick beat.
// One tick per cycle while the level channel does not stall, except a tick that
// starts a nonzero-duration segment: the divider holds tick.ready low until done.
// Reset clears all registers, configuration included; no clearing pass.
// ----------------------------------------------------------------------------
module triggered_linear_segment_envelope_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tlse_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tlse_pkg::CFG_DATA_W-1:0]       cfg_data,
    tlse_tick_if.sink                             tick,
    tlse_level_if.source                          envelope
);

    logic signed [tlse_pkg::LEVEL_W-1:0]     levels_reg [4];
    logic [tlse_pkg::DURATION_BITS-1:0]      durations_reg [tlse_pkg::MAX_SEGMENTS];

    logic                                    playing_reg, playing_next;
    logic [tlse_pkg::SEG_W-1:0]              seg_reg, seg_next;
    logic [tlse_pkg::COUNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [tlse_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic signed [tlse_pkg::ACC_W-1:0]       inc_reg, inc_next;
    logic                                    busy_reg, busy_next;
    logic                                    out_valid_reg, out_valid_next;
    logic signed [tlse_pkg::LEVEL_W-1:0]     level_reg, level_next;

    logic                                    accept;
    logic                                    launch;
    logic [tlse_pkg::SEG_W-1:0]              div_seg;
    logic [tlse_pkg::SEG_W-1:0]              div_seg_nxt;
    logic signed [tlse_pkg::LEVEL_W-1:0]     seg_from;
    logic signed [tlse_pkg::LEVEL_W-1:0]     seg_to;
    logic [tlse_pkg::DURATION_BITS-1:0]      div_dur;
    logic signed [tlse_pkg::DIFF_W-1:0]      diff;
    logic [tlse_pkg::DIFF_W-1:0]             diff_mag;
    logic [tlse_pkg::ACC_W:0]                sum;
    logic signed [tlse_pkg::ACC_W-1:0]       sum_sat;
    logic                                    last_seg;
    tlse_pkg::div_req_t                      div_req;
    tlse_pkg::div_rsp_t                      div_rsp;

    assign accept = tick.valid && tick.ready;
    assign tick.ready = !busy_reg && (!out_valid_reg || envelope.ready);
    assign envelope.valid = out_valid_reg;
    assign envelope.level = level_reg;

    // The next segment's slope: from its start breakpoint to its target.
    assign div_seg     = playing_reg ? seg_reg + 1'b1 : '0;
    assign div_seg_nxt = div_seg + 1'b1;
    assign last_seg    = ({1'b0, div_seg} + 1'b1) >= (tlse_pkg::SEG_W + 1)'(tlse_pkg::NUM_SEGMENTS);
    assign seg_from    = levels_reg[div_seg];
    assign seg_to      = last_seg ? levels_reg[3] : levels_reg[div_seg_nxt];
    assign div_dur     = durations_reg[div_seg];
    assign diff        = {seg_to[tlse_pkg::LEVEL_W-1], seg_to}
                       - {seg_from[tlse_pkg::LEVEL_W-1], seg_from};
    assign diff_mag    = diff[tlse_pkg::DIFF_W-1] ? -diff : diff;

    assign div_req.start    = launch && (div_dur != '0);
    assign div_req.neg      = diff[tlse_pkg::DIFF_W-1];
    assign div_req.dividend = {diff_mag, {tlse_pkg::FRAC_SHIFT{1'b0}}};
    assign div_req.divisor  = div_dur;

    assign sum = {acc_reg[tlse_pkg::ACC_W-1], acc_reg} + {inc_reg[tlse_pkg::ACC_W-1], inc_reg};

    always_comb
    begin
        if (sum[tlse_pkg::ACC_W] != sum[tlse_pkg::ACC_W-1])
        begin
            sum_sat = sum[tlse_pkg::ACC_W] ? tlse_pkg::ACC_MIN : tlse_pkg::ACC_MAX;
        end
        else
        begin
            sum_sat = sum[tlse_pkg::ACC_W-1:0];
        end
    end

    tlse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        playing_next   = playing_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        inc_next       = inc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !envelope.ready;
        level_next     = level_reg;
        launch         = 1'b0;

        if (div_rsp.done)
        begin
            inc_next  = div_rsp.quotient;
            busy_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            if (!playing_reg)
            begin
                seg_next = '0;
                cnt_next = '0;
                if (tick.trigger)
                begin
                    playing_next = 1'b1;
                    acc_next     = {levels_reg[0], {tlse_pkg::FRAC_SHIFT{1'b0}}};
                    level_next   = levels_reg[0];
                    launch       = 1'b1;
                end
                else
                begin
                    acc_next   = {levels_reg[3], {tlse_pkg::FRAC_SHIFT{1'b0}}};
                    level_next = levels_reg[3];
                end
            end
            else if (cnt_reg < {1'b0, durations_reg[seg_reg]})
            begin
                acc_next   = sum_sat;
                cnt_next   = cnt_reg + {{(tlse_pkg::COUNT_W - tlse_pkg::STEP_W){1'b0}},
                                        tick.step_count};
                level_next = sum_sat[tlse_pkg::ACC_W-1:tlse_pkg::FRAC_SHIFT];
            end
            else
            begin
                cnt_next = '0;
                if (({1'b0, seg_reg} + 1'b1) >=
                    (tlse_pkg::SEG_W + 1)'(tlse_pkg::NUM_SEGMENTS))
                begin
                    playing_next = 1'b0;
                    seg_next     = '0;
                    acc_next     = {levels_reg[3], {tlse_pkg::FRAC_SHIFT{1'b0}}};
                    level_next   = levels_reg[3];
                end
                else
                begin
                    seg_next   = seg_reg + 1'b1;
                    launch     = 1'b1;
                    level_next = acc_reg[tlse_pkg::ACC_W-1:tlse_pkg::FRAC_SHIFT];
                end
            end
        end

        if (launch)
        begin
            if (div_dur == '0)
            begin
                inc_next = '0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg   <= 1'b0;
            seg_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            inc_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            playing_reg   <= playing_next;
            seg_reg       <= seg_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            inc_reg       <= inc_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                levels_reg[i] <= '0;
            end
            for (int i = 0; i < tlse_pkg::MAX_SEGMENTS; i++)
            begin
                durations_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (tlse_pkg::reg_index_t'(cfg_index))
                tlse_pkg::REG_LEVEL_START:
                    levels_reg[0] <= cfg_data[tlse_pkg::LEVEL_W-1:0];
                tlse_pkg::REG_LEVEL_ONE:
                    levels_reg[1] <= cfg_data[tlse_pkg::LEVEL_W-1:0];
                tlse_pkg::REG_LEVEL_TWO:
                    levels_reg[2] <= cfg_data[tlse_pkg::LEVEL_W-1:0];
                tlse_pkg::REG_LEVEL_END:
                    levels_reg[3] <= cfg_data[tlse_pkg::LEVEL_W-1:0];
                tlse_pkg::REG_FIRST_DURATION:
                    durations_reg[0] <= cfg_data[tlse_pkg::DURATION_BITS-1:0];
                tlse_pkg::REG_SECOND_DURATION:
                    durations_reg[1] <= cfg_data[tlse_pkg::DURATION_BITS-1:0];
                tlse_pkg::REG_THIRD_DURATION:
                    durations_reg[2] <= cfg_data[tlse_pkg::DURATION_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A finished division always belongs to a tick that is still holding input off.
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> busy_reg)
        else $error("divider finished with no pending segment start");

    // Every accepted tick leaves a level beat waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no level beat");

    // Idle keeps the segment index and counter cleared.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !playing_reg |-> (seg_reg == '0) && (cnt_reg == '0))
        else $error("segment state not cleared while idle");

    // The segment index never passes the last segment.
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, seg_reg} < (tlse_pkg::SEG_W + 1)'(tlse_pkg::NUM_SEGMENTS))
        else $error("segment index out of range");

endmodule

// ===== test/triggered_linear_segment_envelope_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Envelope core testbench
// Sends tick beats through a queue-fed driver and checks every level beat
// against an in-bench model of the three-segment envelope. The directed part
// covers saturating slopes, zero steps and masked durations. Random phases
// reload the breakpoints and segment lengths between runs. Both channels
// stall at random, and one phase holds the level channel off for a long time.
// ----------------------------------------------------------------------------
module triggered_linear_segment_envelope_core_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    typedef struct packed {
        logic                        trigger;
        logic [tlse_pkg::STEP_W-1:0] step_count;
    } tick_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [tlse_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tlse_pkg::CFG_DATA_W-1:0]  cfg_data;

    tlse_tick_if  tick_ch ();
    tlse_level_if env_ch ();

    triggered_linear_segment_envelope_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .envelope  (env_ch)
    );

    logic signed [tlse_pkg::LEVEL_W-1:0]   bp_level [4];
    logic [tlse_pkg::DURATION_BITS-1:0]    seg_len [3];

    logic                                  env_playing;
    logic [tlse_pkg::SEG_W-1:0]            env_segment;
    logic [tlse_pkg::COUNT_W-1:0]          env_count;
    logic signed [tlse_pkg::ACC_W-1:0]     env_acc;
    logic signed [tlse_pkg::ACC_W-1:0]     env_slope;

    tick_t                                 pending_ticks [$];
    logic signed [tlse_pkg::LEVEL_W-1:0]   expected_levels [$];
    tick_t                                 offered;
    logic signed [tlse_pkg::LEVEL_W-1:0]   predicted;
    logic signed [tlse_pkg::LEVEL_W-1:0]   wanted;

    bit                                    pacing;
    bit                                    long_hold_pending;
    int                                    tick_gap;
    int                                    hold_left;
    int                                    quiet_cycles;
    int                                    mismatches;
    int                                    ticks_sent;
    int                                    triggers_sent;
    int                                    levels_checked;
    int                                    reg_writes;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [tlse_pkg::ACC_W-1:0] clamp_acc(input longint v);
        if (v > longint'(tlse_pkg::ACC_MAX))
            return tlse_pkg::ACC_MAX;
        if (v < longint'(tlse_pkg::ACC_MIN))
            return tlse_pkg::ACC_MIN;
        return v[tlse_pkg::ACC_W-1:0];
    endfunction

    function automatic logic signed [tlse_pkg::ACC_W-1:0] segment_slope(input int seg);
        longint                              rise;
        longint                              span;
        logic signed [tlse_pkg::LEVEL_W-1:0] target;
        target = (seg + 1 >= tlse_pkg::NUM_SEGMENTS) ? bp_level[tlse_pkg::REG_LEVEL_END]
                                                     : bp_level[seg + 1];
        rise = (longint'(target) - longint'(bp_level[seg])) * 256;
        span = longint'(seg_len[seg]);
        if (span == 0)
            return '0;
        return clamp_acc(rise / span);
    endfunction

    function automatic logic signed [tlse_pkg::LEVEL_W-1:0] advance_envelope(
        input logic trig, input logic [tlse_pkg::STEP_W-1:0] stride);
        if (!env_playing)
        begin
            env_segment = '0;
            env_count = '0;
            if (trig)
            begin
                env_playing = 1'b1;
                env_acc = {bp_level[tlse_pkg::REG_LEVEL_START], 8'h00};
                env_slope = segment_slope(0);
            end
            else
                env_acc = {bp_level[tlse_pkg::REG_LEVEL_END], 8'h00};
        end
        else if (env_count < seg_len[env_segment])
        begin
            env_acc = clamp_acc(longint'(env_acc) + longint'(env_slope));
            env_count = env_count + stride;
        end
        else
        begin
            env_count = '0;
            if (int'(env_segment) + 1 >= tlse_pkg::NUM_SEGMENTS)
            begin
                env_playing = 1'b0;
                env_segment = '0;
                env_acc = {bp_level[tlse_pkg::REG_LEVEL_END], 8'h00};
            end
            else
            begin
                env_segment = env_segment + 1'b1;
                env_slope = segment_slope(int'(env_segment));
            end
        end
        return env_acc[tlse_pkg::ACC_W-1:tlse_pkg::FRAC_SHIFT];
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic write_reg(input tlse_pkg::reg_index_t idx,
                             input logic [tlse_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx <= tlse_pkg::REG_LEVEL_END)
            bp_level[idx] = data[tlse_pkg::LEVEL_W-1:0];
        else
            seg_len[idx - tlse_pkg::REG_FIRST_DURATION] = data[tlse_pkg::DURATION_BITS-1:0];
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_shape(input logic [tlse_pkg::CFG_DATA_W-1:0] l0,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] l1,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] l2,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] l3,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] d0,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] d1,
                              input logic [tlse_pkg::CFG_DATA_W-1:0] d2);
        write_reg(tlse_pkg::REG_LEVEL_START, l0);
        write_reg(tlse_pkg::REG_LEVEL_ONE, l1);
        write_reg(tlse_pkg::REG_LEVEL_TWO, l2);
        write_reg(tlse_pkg::REG_LEVEL_END, l3);
        write_reg(tlse_pkg::REG_FIRST_DURATION, d0);
        write_reg(tlse_pkg::REG_SECOND_DURATION, d1);
        write_reg(tlse_pkg::REG_THIRD_DURATION, d2);
    endtask

    function automatic logic [tlse_pkg::CFG_DATA_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            default: return tlse_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [tlse_pkg::CFG_DATA_W-1:0] random_length(input int longest);
        logic [tlse_pkg::CFG_DATA_W-1:0] data;
        data = tlse_pkg::CFG_DATA_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            data[tlse_pkg::DURATION_BITS-1:0] = '0;
        else
            data[tlse_pkg::DURATION_BITS-1:0] =
                tlse_pkg::DURATION_BITS'($urandom_range(1, longest));
        return data;
    endfunction

    task automatic queue_tick(input logic trig, input int stride);
        tick_t t;
        t.trigger = trig;
        t.step_count = tlse_pkg::STEP_W'(stride);
        pending_ticks = {pending_ticks, t};
    endtask

    task automatic queue_random_ticks(input int count);
        int pick;
        int stride;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 7)
                stride = 0;
            else if (pick < 15)
                stride = $urandom_range(65, 127);
            else
                stride = $urandom_range(1, 64);
            queue_tick($urandom_range(0, 99) < 12, stride);
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_levels.size() != 0
               || !tick_ch.ready);
    endtask

    task automatic wait_sent();
        while (pending_ticks.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.trigger <= 1'b0;
            tick_ch.step_count <= '0;
            tick_gap = 0;
            ticks_sent = 0;
            triggers_sent = 0;
            env_playing = 1'b0;
            env_segment = '0;
            env_count = '0;
            env_acc = '0;
            env_slope = '0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                predicted = advance_envelope(tick_ch.trigger, tick_ch.step_count);
                expected_levels = {expected_levels, predicted};
                ticks_sent++;
                if (tick_ch.trigger)
                    triggers_sent++;
            end
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_gap > 0)
                begin
                    tick_gap--;
                    tick_ch.valid <= 1'b0;
                end
                else if (pacing && $urandom_range(0, 11) == 0)
                begin
                    tick_gap = $urandom_range(0, 5);
                    tick_ch.valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    offered = pending_ticks.pop_front();
                    tick_ch.valid <= 1'b1;
                    tick_ch.trigger <= offered.trigger;
                    tick_ch.step_count <= offered.step_count;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_ch.ready <= 1'b0;
            hold_left = 0;
            mismatches = 0;
            levels_checked = 0;
        end
        else
        begin
            if (env_ch.valid && env_ch.ready)
            begin
                if (expected_levels.size() == 0)
                    note_mismatch($sformatf("level beat %h with no tick waiting", env_ch.level));
                else
                begin
                    wanted = expected_levels.pop_front();
                    levels_checked++;
                    if (env_ch.level !== wanted)
                        note_mismatch($sformatf("level %h, expected %h on beat %0d",
                                                env_ch.level, wanted, levels_checked));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                env_ch.ready <= 1'b0;
            end
            else if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                hold_left = LONG_HOLD - 1;
                env_ch.ready <= 1'b0;
            end
            else if (pacing && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 5);
                env_ch.ready <= 1'b0;
            end
            else
                env_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (env_ch.valid && env_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("triggered_linear_segment_envelope_core_test NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int longest;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tlse_pkg::REG_LEVEL_START;
        cfg_data = '0;
        for (int i = 0; i < 4; i++)
            bp_level[i] = '0;
        for (int i = 0; i < 3; i++)
            seg_len[i] = '0;
        pacing = 1'b1;
        long_hold_pending = 1'b0;
        reg_writes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset shape: every segment has zero length, so a trigger plays straight through.
        queue_tick(1'b0, 5);
        queue_tick(1'b1, 1);
        queue_tick(1'b0, 0);
        queue_tick(1'b1, 64);
        queue_tick(1'b0, 127);
        drain();

        // Full-scale rise over one sample saturates the slope; zero steps then
        // push the accumulator into saturation. Duration upper bits are masked.
        load_shape(24'h800000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF,
                   24'h000001, 24'hFFFFFF, 24'hF00000);
        queue_tick(1'b1, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 127);
        queue_tick(1'b0, 1);
        queue_tick(1'b1, 64);
        queue_tick(1'b1, 1);
        drain();

        // Full-scale fall, saturating low; the running envelope sees its
        // remaining segments shortened to zero.
        load_shape(24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000,
                   24'h000001, 24'h000000, 24'h000000);
        queue_tick(1'b0, 3);
        queue_tick(1'b0, 3);
        queue_tick(1'b1, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 0);
        queue_tick(1'b0, 2);
        queue_tick(1'b0, 1);
        queue_tick(1'b0, 1);
        queue_tick(1'b0, 1);
        drain();

        for (int p = 0; p < 14; p++)
        begin
            pacing = (p < 11);
            longest = (p == 3) ? (1 << tlse_pkg::DURATION_BITS) - 1 : $urandom_range(8, 400);
            for (int r = tlse_pkg::REG_LEVEL_START; r <= tlse_pkg::REG_LEVEL_END; r++)
                write_reg(tlse_pkg::reg_index_t'(r), random_level());
            for (int r = tlse_pkg::REG_FIRST_DURATION; r <= tlse_pkg::REG_THIRD_DURATION; r++)
                write_reg(tlse_pkg::reg_index_t'(r), random_length(longest));
            queue_tick(1'b1, $urandom_range(1, 64));
            queue_random_ticks(49);
            if (p == 5)
            begin
                wait_sent();
                long_hold_pending = 1'b1;
            end
            else if (p == 7)
                drain();
            queue_random_ticks(50);
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d level beats from %0d ticks (%0d with trigger set)",
                 levels_checked, ticks_sent, triggers_sent);
        $display("over %0d register writes, from zero-length to full-scale segments.",
                 reg_writes);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("triggered_linear_segment_envelope_core_test OK");
        else
            $display("triggered_linear_segment_envelope_core_test NOT OK");
        $finish;
    end

endmodule

// ===== triggered_linear_segment_envelope_core.f =====
design/tlse_pkg.sv
design/tlse_if.sv
design/tlse_div.sv
design/triggered_linear_segment_envelope_core.sv
test/triggered_linear_segment_envelope_core_test.sv
